FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define BRA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define BRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bra_pkg.sv
// Shared types and constants of the bitmap region allocator.
package bra_pkg;

   localparam int CNT_W      = 10;
   localparam int SIZE_W     = 16;
   localparam int ADDR_W     = 48;
   localparam int WANT_W     = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int WORD_W     = 32;
   localparam int WORD_IDX_W = 5;
   localparam int CMD_DEPTH  = 2;
   localparam int OUT_DEPTH  = 4;

   localparam logic [0:0] OP_INIT  = 1'b0;
   localparam logic [0:0] OP_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INIT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_BASE     = 2'd2;

   localparam logic [CNT_W-1:0]  RCOUNT_RST = 10'd512;
   localparam logic [SIZE_W-1:0] RSIZE_RST  = 16'd16;
   localparam logic [ADDR_W-1:0] RBASE_RST  = 48'd0;

   typedef struct packed {
      logic [0:0]        op;
      logic [WANT_W-1:0] want;
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_ctl_type;

   // Position of the lowest set bit; zero when no bit is set.
   function automatic logic [WORD_IDX_W-1:0] bra_ffs(input logic [WORD_W-1:0] word);
      logic [WORD_IDX_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = WORD_IDX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

FILE: design/bra_front.sv
// Request intake: normalizes the wanted count and queues commands for the engine.
module bra_front #(
   parameter int MAX_BATCH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_type,
   input  logic [6:0]       req_want_count,
   input  logic             clearing,
   output logic             cmd_valid,
   output bra_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import bra_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_Q_W = $clog2(CMD_DEPTH + 1);

   cmd_type               queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q_W-1:0]    count_ff, count_in;
   cmd_type               new_cmd;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      new_cmd.op = req_type;
      if (req_want_count == '0) begin
         new_cmd.want = WANT_W'(1);
      end else if (32'(req_want_count) > MAX_BATCH) begin
         new_cmd.want = WANT_W'(MAX_BATCH);
      end else begin
         new_cmd.want = req_want_count;
      end
   end

   assign full      = (count_ff == CNT_Q_W'(CMD_DEPTH)) || clearing;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_Q_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_Q_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: design/bra_engine.sv
// Allocation engine: owns the free bitmap and the free counter, scans for grants.
module bra_engine #(
   parameter int MAX_REGIONS = 512,
   parameter int IDX_W       = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [9:0]            eff_count,
   input  logic                  cmd_valid,
   input  bra_pkg::cmd_type      cmd,
   output logic                  cmd_take,
   input  logic                  room,
   output bra_pkg::rsp_ctl_type  ctl,
   output logic [IDX_W-1:0]      idx,
   output logic                  clearing
);
   import bra_pkg::*;

   localparam int NWORDS    = (MAX_REGIONS + WORD_W - 1) / WORD_W;
   localparam int WP_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CMP_W     = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int FREE_RST  = (MAX_REGIONS < 512) ? MAX_REGIONS : 512;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INIT  = 3'd2;
   localparam logic [2:0] S_IDONE = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_LOAD  = 3'd5;
   localparam logic [2:0] S_SCAN  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [WORD_W-1:0]     bitmap_mem [NWORDS];
   logic [WORD_W-1:0]     rd_data_ff;

   logic [2:0]            state_ff, state_in;
   logic [WP_W-1:0]       word_ptr_ff, word_ptr_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [WANT_W-1:0]     k_ff, k_in;
   logic [WANT_W-1:0]     limit_ff, limit_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [IDX_W-1:0]      hold_idx_ff, hold_idx_in;
   logic [CNT_W-1:0]      free_total_ff, free_total_in;

   logic                  mem_we;
   logic [WORD_W-1:0]     mem_wdata;
   logic [CMP_W-1:0]      base;
   logic [CMP_W-1:0]      base_end;
   logic [CMP_W-1:0]      n_ext;
   logic [CMP_W-1:0]      diff_w;
   logic [WORD_W-1:0]     lim_mask;
   logic [WORD_W-1:0]     avail;
   logic [WORD_IDX_W-1:0] ff_pos;
   logic [CMP_W-1:0]      found_full;
   logic                  scan_last;
   logic                  ptr_last;

   always_comb begin
      base       = CMP_W'(word_ptr_ff) << WORD_IDX_W;
      base_end   = base + CMP_W'(WORD_W);
      n_ext      = CMP_W'(eff_count);
      diff_w     = n_ext - base;
      if (base_end <= n_ext) begin
         lim_mask = '1;
      end else if (base >= n_ext) begin
         lim_mask = '0;
      end else begin
         lim_mask = ~({WORD_W{1'b1}} << diff_w[WORD_IDX_W-1:0]);
      end
      avail      = word_ff & lim_mask;
      ff_pos     = bra_ffs(avail);
      found_full = base + CMP_W'(ff_pos);
      ptr_last   = (word_ptr_ff == WP_W'(NWORDS - 1));
      scan_last  = (base_end >= n_ext) || ptr_last;
   end

   always_comb begin
      state_in      = state_ff;
      word_ptr_in   = word_ptr_ff;
      word_in       = word_ff;
      k_in          = k_ff;
      limit_in      = limit_ff;
      hold_valid_in = hold_valid_ff;
      hold_idx_in   = hold_idx_ff;
      free_total_in = free_total_ff;
      mem_we        = 1'b0;
      mem_wdata     = word_ff;
      cmd_take      = 1'b0;
      ctl           = '0;
      idx           = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '1;
            if (ptr_last) begin
               word_ptr_in = '0;
               state_in    = S_IDLE;
            end else begin
               word_ptr_in = word_ptr_ff + WP_W'(1);
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take      = 1'b1;
               word_ptr_in   = '0;
               k_in          = '0;
               hold_valid_in = 1'b0;
               if (cmd.op == OP_INIT) begin
                  free_total_in = eff_count;
                  state_in      = S_INIT;
               end else begin
                  if (CNT_W'(cmd.want) < free_total_ff) begin
                     limit_in = cmd.want;
                  end else begin
                     limit_in = free_total_ff[WANT_W-1:0];
                  end
                  state_in = (limit_in == '0) ? S_FIN : S_READ;
               end
            end
         end
         S_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = lim_mask;
            if (ptr_last) begin
               state_in = S_IDONE;
            end else begin
               word_ptr_in = word_ptr_ff + WP_W'(1);
            end
         end
         S_IDONE: begin
            if (room) begin
               ctl.valid  = 1'b1;
               ctl.status = ST_INIT;
               ctl.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            word_in  = rd_data_ff;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if ((k_ff == limit_ff) || (avail == '0)) begin
               // The word is finished; put back what is left of it.
               mem_we = 1'b1;
               if ((k_ff == limit_ff) || scan_last) begin
                  state_in = S_FIN;
               end else begin
                  word_ptr_in = word_ptr_ff + WP_W'(1);
                  state_in    = S_READ;
               end
            end else if (!hold_valid_ff || room) begin
               // A grant is held back one step so the final one can carry last.
               if (hold_valid_ff) begin
                  ctl.valid  = 1'b1;
                  ctl.status = ST_GRANT;
                  ctl.last   = 1'b0;
                  idx        = hold_idx_ff;
               end
               hold_valid_in = 1'b1;
               hold_idx_in   = found_full[IDX_W-1:0];
               word_in       = word_ff & ~({{(WORD_W-1){1'b0}}, 1'b1} << ff_pos);
               k_in          = k_ff + WANT_W'(1);
            end
         end
         S_FIN: begin
            if (room) begin
               ctl.valid = 1'b1;
               ctl.last  = 1'b1;
               if (hold_valid_ff) begin
                  ctl.status = ST_GRANT;
                  idx        = hold_idx_ff;
               end else begin
                  ctl.status = ST_NONE;
               end
               free_total_in = free_total_ff - CNT_W'(k_ff);
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign clearing = (state_ff == S_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         word_ptr_ff   <= '0;
         hold_valid_ff <= 1'b0;
         free_total_ff <= CNT_W'(FREE_RST);
         k_ff          <= '0;
         limit_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         word_ptr_ff   <= word_ptr_in;
         hold_valid_ff <= hold_valid_in;
         free_total_ff <= free_total_in;
         k_ff          <= k_in;
         limit_ff      <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      hold_idx_ff <= hold_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[word_ptr_ff] <= mem_wdata;
      end
      rd_data_ff <= bitmap_mem[word_ptr_ff];
   end

endmodule

FILE: design/bra_rsp.sv
// Result side: address computation pipeline and the result queue.
module bra_rsp #(
   parameter int IDX_W = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bra_pkg::rsp_ctl_type  ctl,
   input  logic [IDX_W-1:0]      idx,
   input  logic [15:0]           slot_bytes,
   input  logic [47:0]           run_base,
   output logic                  room,
   output logic                  empty,
   input  logic                  pop,
   output logic [IDX_W-1:0]      rsp_region_index,
   output logic [47:0]           rsp_region_addr,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);
   import bra_pkg::*;

   localparam int PROD_W  = SIZE_W + IDX_W;
   localparam int PTR_W   = $clog2(OUT_DEPTH);
   localparam int CNT_Q_W = $clog2(OUT_DEPTH + 1);
   localparam int SUM_W   = CNT_Q_W + 1;

   rsp_ctl_type           a_ctl_ff;
   logic [IDX_W-1:0]      a_idx_ff;
   rsp_ctl_type           b_ctl_ff;
   logic [IDX_W-1:0]      b_idx_ff;
   logic [PROD_W-1:0]     b_prod_ff;
   logic [ADDR_W-1:0]     b_addr;

   logic [IDX_W-1:0]      q_idx_ff    [OUT_DEPTH];
   logic [ADDR_W-1:0]     q_addr_ff   [OUT_DEPTH];
   logic [STATUS_W-1:0]   q_status_ff [OUT_DEPTH];
   logic                  q_last_ff   [OUT_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]      pending;
   logic                  do_pop;

   // Counting the stages in flight keeps every queued result a free slot.
   assign pending = SUM_W'(count_ff) + SUM_W'(a_ctl_ff.valid) + SUM_W'(b_ctl_ff.valid);
   assign room    = (pending < SUM_W'(OUT_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_pop  = pop && !empty;

   assign b_addr = (b_ctl_ff.status == ST_GRANT) ? run_base + ADDR_W'(b_prod_ff) : '0;

   assign rsp_region_index = q_idx_ff[rd_ptr_ff];
   assign rsp_region_addr  = q_addr_ff[rd_ptr_ff];
   assign rsp_status       = q_status_ff[rd_ptr_ff];
   assign rsp_last         = q_last_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (b_ctl_ff.valid) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (b_ctl_ff.valid && !do_pop) begin
         count_in = count_ff + CNT_Q_W'(1);
      end else if (do_pop && !b_ctl_ff.valid) begin
         count_in = count_ff - CNT_Q_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff  <= '0;
         b_ctl_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         a_ctl_ff  <= ctl;
         b_ctl_ff  <= a_ctl_ff;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff  <= idx;
      b_idx_ff  <= a_idx_ff;
      b_prod_ff <= PROD_W'(slot_bytes) * PROD_W'(a_idx_ff);
      if (b_ctl_ff.valid) begin
         q_idx_ff[wr_ptr_ff]    <= b_idx_ff;
         q_addr_ff[wr_ptr_ff]   <= b_addr;
         q_status_ff[wr_ptr_ff] <= b_ctl_ff.status;
         q_last_ff[wr_ptr_ff]   <= b_ctl_ff.last;
      end
   end

endmodule

FILE: design/bitmap_region_allocator_top.sv
// Top level of the bitmap region allocator: configuration registers and block wiring.
//
// A request queue (2 deep) feeds an engine that keeps the free bitmap in a memory of
// 32-bit words and a result queue (4 deep) holds finished results. After reset the
// engine sets the whole bitmap free in a clearing pass over every bitmap word while
// full stays high. An init request writes each bitmap word in turn and then reports
// its result. An allocate visits bitmap words in order: each visit reads the word,
// waits out the read latency, grants regions from it one at a time, and closes by
// writing the word back. Each result then passes the address pipeline (one multiply,
// one add) before it enters the result queue.
module bitmap_region_allocator_top #(
   parameter int MAX_REGIONS = 512,
   parameter int MAX_BATCH   = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_type,
   input  logic [6:0]                       req_want_count,
   output logic                             empty,
   input  logic                             pop,
   output logic [$clog2(MAX_REGIONS)-1:0]   rsp_region_index,
   output logic [47:0]                      rsp_region_addr,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [1:0]                       csr_index,
   input  logic [47:0]                      csr_wdata
);
   import bra_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(MAX_REGIONS);

   logic [CNT_W-1:0]  region_count_ff;
   logic [SIZE_W-1:0] slot_bytes_ff;
   logic [ADDR_W-1:0] run_base_ff;
   logic [CNT_W-1:0]  eff_count;
   logic              csr_write;

   logic              clearing;
   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_take;
   logic              rsp_room;
   rsp_ctl_type       eng_ctl;
   logic [IDX_W-1:0]  eng_idx;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_count_ff <= RCOUNT_RST;
         slot_bytes_ff   <= RSIZE_RST;
         run_base_ff     <= RBASE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_REGION_COUNT: region_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_SLOT_BYTES:   slot_bytes_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_RUN_BASE:     run_base_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign eff_count = (32'(region_count_ff) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                            : region_count_ff;

   bra_front #(
      .MAX_BATCH (MAX_BATCH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_want_count (req_want_count),
      .clearing       (clearing),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   bra_engine #(
      .MAX_REGIONS (MAX_REGIONS),
      .IDX_W       (IDX_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .eff_count (eff_count),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .room      (rsp_room),
      .ctl       (eng_ctl),
      .idx       (eng_idx),
      .clearing  (clearing)
   );

   bra_rsp #(
      .IDX_W (IDX_W)
   ) u_rsp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (eng_ctl),
      .idx              (eng_idx),
      .slot_bytes       (slot_bytes_ff),
      .run_base         (run_base_ff),
      .room             (rsp_room),
      .empty            (empty),
      .pop              (pop),
      .rsp_region_index (rsp_region_index),
      .rsp_region_addr  (rsp_region_addr),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   `BRA_ASSERT_IMP(a_full_after_reset, clock, reset, $fell(reset), full, "full low during clearing pass")
   `BRA_ASSERT_IMP(a_push_has_room, clock, reset, eng_ctl.valid, rsp_room, "result pushed without a free slot")
   `BRA_ASSERT_IMP(a_nongrant_shape, clock, reset, !empty && (rsp_status != ST_GRANT), rsp_last && (rsp_region_index == '0) && (rsp_region_addr == '0), "init or error result malformed")
   `BRA_ASSERT_NEXT(a_take_once, clock, reset, cmd_take && cmd_valid, !cmd_take, "engine took two commands back to back")

endmodule
